### rtl/tgr_pkg.sv
package tgr_pkg;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  localparam int unsigned GLYPH_ROWS = 5;
  localparam int unsigned GLYPH_COLS = 3;
  localparam logic [9:0]  ADVANCE_X  = 10'd4;
  localparam logic [7:0]  ADVANCE_Y  = 8'd6;
  localparam logic [6:0]  LINE_LEN_RST = 7'd76;

  typedef logic [4:0][2:0] glyph_t;

  typedef struct packed {
    logic [7:0]  character;
    logic        first;
    logic [8:0]  start_x;
    logic [7:0]  start_y;
    logic [31:0] color;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  pos_x;
    logic [7:0]  pos_y;
    logic [14:0] mask;
    logic [31:0] pixel_color;
  } out_res_t;

  // rows listed top to bottom; bit 2 of a row is the left column
  function automatic glyph_t gl(input logic [2:0] r0, input logic [2:0] r1,
                                input logic [2:0] r2, input logic [2:0] r3,
                                input logic [2:0] r4);
    glyph_t g;
    g[0] = r0;
    g[1] = r1;
    g[2] = r2;
    g[3] = r3;
    g[4] = r4;
    return g;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] ch);
    logic [7:0] u;
    glyph_t     g;
    // fold lower case to upper case
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      u = ch - 8'h20;
    end else begin
      u = ch;
    end
    case (u)
      8'h30: g = gl(7, 5, 5, 5, 7);
      8'h31: g = gl(2, 6, 2, 2, 7);
      8'h32: g = gl(7, 1, 7, 4, 7);
      8'h33: g = gl(7, 1, 7, 1, 7);
      8'h34: g = gl(5, 5, 7, 1, 1);
      8'h35: g = gl(7, 4, 7, 1, 7);
      8'h36: g = gl(7, 4, 7, 5, 7);
      8'h37: g = gl(7, 1, 1, 1, 1);
      8'h38: g = gl(7, 5, 7, 5, 7);
      8'h39: g = gl(7, 5, 7, 1, 7);
      8'h41: g = gl(2, 5, 7, 5, 5);
      8'h42: g = gl(6, 5, 6, 5, 6);
      8'h43: g = gl(7, 4, 4, 4, 7);
      8'h44: g = gl(6, 5, 5, 5, 6);
      8'h45: g = gl(7, 4, 6, 4, 7);
      8'h46: g = gl(7, 4, 6, 4, 4);
      8'h47: g = gl(7, 4, 5, 5, 7);
      8'h48: g = gl(5, 5, 7, 5, 5);
      8'h49: g = gl(7, 2, 2, 2, 7);
      8'h4A: g = gl(1, 1, 1, 5, 7);
      8'h4B: g = gl(5, 5, 6, 5, 5);
      8'h4C: g = gl(4, 4, 4, 4, 7);
      8'h4D: g = gl(5, 7, 7, 5, 5);
      8'h4E: g = gl(5, 7, 7, 7, 5);
      8'h4F: g = gl(7, 5, 5, 5, 7);
      8'h50: g = gl(7, 5, 7, 4, 4);
      8'h51: g = gl(7, 5, 5, 7, 1);
      8'h52: g = gl(6, 5, 6, 5, 5);
      8'h53: g = gl(7, 4, 7, 1, 7);
      8'h54: g = gl(7, 2, 2, 2, 2);
      8'h55: g = gl(5, 5, 5, 5, 7);
      8'h56: g = gl(5, 5, 5, 5, 2);
      8'h57: g = gl(5, 5, 7, 7, 5);
      8'h58: g = gl(5, 5, 2, 5, 5);
      8'h59: g = gl(5, 5, 2, 2, 2);
      8'h5A: g = gl(7, 1, 2, 4, 7);
      8'h5B: g = gl(6, 4, 4, 4, 6);  // [
      8'h5D: g = gl(3, 1, 1, 1, 3);  // ]
      8'h3D: g = gl(0, 7, 0, 7, 0);  // =
      8'h2D: g = gl(0, 0, 7, 0, 0);  // -
      8'h3A: g = gl(0, 2, 0, 2, 0);  // :
      8'h2E: g = gl(0, 0, 0, 0, 2);  // .
      8'h2F: g = gl(1, 1, 2, 4, 4);  // /
      8'h5F: g = gl(0, 0, 0, 0, 7);  // _
      8'h3C: g = gl(1, 2, 4, 2, 1);  // <
      8'h3E: g = gl(4, 2, 1, 2, 4);  // >
      8'h23: g = gl(5, 7, 5, 7, 5);  // #
      8'h20: g = gl(0, 0, 0, 0, 0);  // space
      default: g = gl(7, 1, 2, 0, 2);  // question mark
    endcase
    return g;
  endfunction

endpackage

### rtl/text_glyph_renderer_top.sv
// Text glyph renderer: turns a stream of text bytes into 3x5 pixel masks.
// Input channel (in_valid/in_stall/in_data) carries one character request per
// cycle unless in_stall is high; first marks the start of a string and loads
// the cursor origin. Output channel (out_valid/out_stall/out_data) carries one
// glyph per byte, unknown bytes as a question mark: position, clipped 15-bit
// mask and color. NUL, CR, LF, bytes past the screen bottom and bytes of a
// stopped string give no output. cfg_valid/cfg_data sets the line length
// (characters before an automatic wrap); cfg_ready is always high. Write it
// only while the block is idle. An accepted request enters the input register,
// then its glyph the result register. The block takes one request per cycle
// while out_stall is low; cursor update and glyph ROM lookup are combinational.
// When the receiver stalls, the result register holds; one more request still
// enters the input register, and requests with no output keep draining.
// Reset (synchronous, rst_n low) empties both registers, clears the cursor,
// sets the line length to 76 and leaves drawing stopped until a request with
// first.
module text_glyph_renderer_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 224
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tgr_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tgr_pkg::out_res_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);
  import tgr_pkg::*;

  localparam logic [10:0] SW = 11'(SCREEN_WIDTH);
  localparam logic [8:0]  SH = 9'(SCREEN_HEIGHT);

  logic [6:0] max_cols_r;
  logic [8:0] origin_x_r, origin_x_nxt;
  logic [9:0] cursor_x_r, cursor_x_nxt;
  logic [7:0] cursor_y_r, cursor_y_nxt;
  logic [6:0] col_cnt_r, col_cnt_nxt;
  logic       stopped_r, stopped_nxt;

  logic     s1_valid_r;
  in_req_t  s1_data_r;
  logic     out_valid_r;
  out_res_t out_data_r;

  logic     has_res;
  logic     out_free;
  logic     advance;
  logic     in_take;
  glyph_t   rows;
  logic [14:0] mask;

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!has_res || out_free);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    logic wrap;
    origin_x_nxt = origin_x_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    col_cnt_nxt  = col_cnt_r;
    stopped_nxt  = stopped_r;
    has_res      = 1'b0;
    wrap         = 1'b0;
    if (s1_data_r.first) begin
      origin_x_nxt = s1_data_r.start_x;
      cursor_x_nxt = {1'b0, s1_data_r.start_x};
      cursor_y_nxt = s1_data_r.start_y;
      col_cnt_nxt  = '0;
      stopped_nxt  = 1'b0;
    end
    if (!stopped_nxt) begin
      if (s1_data_r.character == CHAR_NUL ||
          ({1'b0, cursor_y_nxt} + 9'd5) >= SH) begin
        stopped_nxt = 1'b1;
      end else if (s1_data_r.character != CHAR_CR) begin
        wrap = (s1_data_r.character == CHAR_LF) || (col_cnt_nxt >= max_cols_r);
        if (wrap) begin
          cursor_x_nxt = {1'b0, origin_x_nxt};
          cursor_y_nxt = cursor_y_nxt + ADVANCE_Y;
          col_cnt_nxt  = '0;
        end
        has_res = (s1_data_r.character != CHAR_LF);
      end
    end
  end

  // glyph at the (possibly wrapped) cursor, clipped to the screen
  assign rows = glyph_lookup(s1_data_r.character);

  always_comb begin
    mask = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        mask[r*GLYPH_COLS + c] = rows[r][2-c] &&
            (({1'b0, cursor_x_nxt} + 11'(c)) < SW) &&
            (({1'b0, cursor_y_nxt} + 9'(r)) < SH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cols_r  <= LINE_LEN_RST;
      origin_x_r  <= '0;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      col_cnt_r   <= '0;
      stopped_r   <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_cols_r <= cfg_data;
      end
      if (advance) begin
        origin_x_r <= origin_x_nxt;
        cursor_x_r <= has_res ? (cursor_x_nxt + ADVANCE_X) : cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        col_cnt_r  <= has_res ? (col_cnt_nxt + 7'd1) : col_cnt_nxt;
        stopped_r  <= stopped_nxt;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance && has_res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance && has_res) begin
      out_data_r.pos_x       <= cursor_x_nxt;
      out_data_r.pos_y       <= cursor_y_nxt;
      out_data_r.mask        <= mask;
      out_data_r.pixel_color <= s1_data_r.color;
    end
  end

endmodule

### rtl/tgr_checker.sv
module tgr_checker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 224
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tgr_pkg::out_res_t out_data
);
  import tgr_pkg::*;

  localparam logic [9:0] SW10 = 10'(SCREEN_WIDTH);
  localparam logic [7:0] SH8  = 8'(SCREEN_HEIGHT);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a glyph starting right of the screen edge has nothing left to draw
  a_clip_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pos_x >= SW10) |-> out_data.mask == 15'd0)
    else $error("off-screen column lit");

  // a glyph starting below the screen bottom has nothing left to draw
  a_clip_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pos_y >= SH8) |-> out_data.mask == 15'd0)
    else $error("off-screen row lit");

  // reset empties the pipeline; stall is only raised with an item inside
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind text_glyph_renderer_top tgr_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/testbench.sv
module testbench;
  import tgr_pkg::*;

  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 224;
  localparam int HOLD_CYCLES = 250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_req_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_res_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  text_glyph_renderer_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // requests waiting to be sent, glyphs waiting to come back
  in_req_t  char_q[$];
  out_res_t glyph_q[$];

  // cursor state tracked alongside the block
  logic [8:0] org_x = '0;
  logic [9:0] cur_x = '0;
  logic [7:0] cur_y = '0;
  logic [6:0] col_cnt = '0;
  logic       halted = 1'b1;
  logic [6:0] max_cols = LINE_LEN_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_now = 1'b0;
  bit hold_armed;
  int hold_left;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int req_cnt = 0;
  int glyph_cnt = 0;
  int clipped_cnt = 0;
  int wrap_cnt = 0;
  int halt_cnt = 0;

  function automatic logic [14:0] pack5(input logic [2:0] r0, input logic [2:0] r1,
                                        input logic [2:0] r2, input logic [2:0] r3,
                                        input logic [2:0] r4);
    return {r4, r3, r2, r1, r0};
  endfunction

  // row r sits at bits [3r+2:3r], bit 2 of a row is the left column
  function automatic logic [14:0] glyph_rows(input logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (u)
      "0": return pack5(7, 5, 5, 5, 7);
      "1": return pack5(2, 6, 2, 2, 7);
      "2": return pack5(7, 1, 7, 4, 7);
      "3": return pack5(7, 1, 7, 1, 7);
      "4": return pack5(5, 5, 7, 1, 1);
      "5": return pack5(7, 4, 7, 1, 7);
      "6": return pack5(7, 4, 7, 5, 7);
      "7": return pack5(7, 1, 1, 1, 1);
      "8": return pack5(7, 5, 7, 5, 7);
      "9": return pack5(7, 5, 7, 1, 7);
      "A": return pack5(2, 5, 7, 5, 5);
      "B": return pack5(6, 5, 6, 5, 6);
      "C": return pack5(7, 4, 4, 4, 7);
      "D": return pack5(6, 5, 5, 5, 6);
      "E": return pack5(7, 4, 6, 4, 7);
      "F": return pack5(7, 4, 6, 4, 4);
      "G": return pack5(7, 4, 5, 5, 7);
      "H": return pack5(5, 5, 7, 5, 5);
      "I": return pack5(7, 2, 2, 2, 7);
      "J": return pack5(1, 1, 1, 5, 7);
      "K": return pack5(5, 5, 6, 5, 5);
      "L": return pack5(4, 4, 4, 4, 7);
      "M": return pack5(5, 7, 7, 5, 5);
      "N": return pack5(5, 7, 7, 7, 5);
      "O": return pack5(7, 5, 5, 5, 7);
      "P": return pack5(7, 5, 7, 4, 4);
      "Q": return pack5(7, 5, 5, 7, 1);
      "R": return pack5(6, 5, 6, 5, 5);
      "S": return pack5(7, 4, 7, 1, 7);
      "T": return pack5(7, 2, 2, 2, 2);
      "U": return pack5(5, 5, 5, 5, 7);
      "V": return pack5(5, 5, 5, 5, 2);
      "W": return pack5(5, 5, 7, 7, 5);
      "X": return pack5(5, 5, 2, 5, 5);
      "Y": return pack5(5, 5, 2, 2, 2);
      "Z": return pack5(7, 1, 2, 4, 7);
      "[": return pack5(6, 4, 4, 4, 6);
      "]": return pack5(3, 1, 1, 1, 3);
      "=": return pack5(0, 7, 0, 7, 0);
      "-": return pack5(0, 0, 7, 0, 0);
      ":": return pack5(0, 2, 0, 2, 0);
      ".": return pack5(0, 0, 0, 0, 2);
      "/": return pack5(1, 1, 2, 4, 4);
      "_": return pack5(0, 0, 0, 0, 7);
      "<": return pack5(1, 2, 4, 2, 1);
      ">": return pack5(4, 2, 1, 2, 4);
      "#": return pack5(5, 7, 5, 7, 5);
      " ": return '0;
      default: return pack5(7, 1, 2, 0, 2);
    endcase
  endfunction

  function automatic logic [14:0] clip_mask(input logic [7:0] ch, input logic [9:0] x,
                                            input logic [7:0] y);
    logic [14:0] rows;
    logic [14:0] m;
    rows = glyph_rows(ch);
    m = '0;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rows[r*3 + 2 - c] && int'(x) + c < SCREEN_W && int'(y) + r < SCREEN_H) begin
          m[r*3 + c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // unclipped mask in output bit order, to tell clipped glyphs apart
  function automatic logic [14:0] glyph_rows_lr(input in_req_t rq);
    return clip_mask(rq.character, 10'd0, 8'd0);
  endfunction

  // advance the cursor for one accepted request, queue the glyph it draws
  task automatic render_char(input in_req_t rq);
    out_res_t res;
    if (rq.first) begin
      org_x = rq.start_x;
      cur_x = {1'b0, rq.start_x};
      cur_y = rq.start_y;
      col_cnt = '0;
      halted = 1'b0;
    end
    if (halted) return;
    if (rq.character == CHAR_NUL || 32'(cur_y) + GLYPH_ROWS >= SCREEN_H) begin
      halted = 1'b1;
      halt_cnt++;
      return;
    end
    if (rq.character == CHAR_CR) return;
    if (rq.character == CHAR_LF || col_cnt >= max_cols) begin
      cur_x = {1'b0, org_x};
      cur_y = cur_y + ADVANCE_Y;
      col_cnt = '0;
      wrap_cnt++;
      if (rq.character == CHAR_LF) return;
    end
    res.pos_x = cur_x;
    res.pos_y = cur_y;
    res.mask = clip_mask(rq.character, cur_x, cur_y);
    res.pixel_color = rq.color;
    if (res.mask != glyph_rows_lr(rq))
      clipped_cnt++;
    glyph_q.push_back(res);
    cur_x = cur_x + ADVANCE_X;
    col_cnt = col_cnt + 7'd1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_glyph(input out_res_t got);
    out_res_t want;
    if (glyph_q.size() == 0) begin
      report_mismatch($sformatf("glyph with none pending: x=%0d y=%0d mask=%h",
                                got.pos_x, got.pos_y, got.mask));
      return;
    end
    want = glyph_q.pop_front();
    glyph_cnt++;
    if (got.pos_x !== want.pos_x)
      report_mismatch($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
    if (got.pos_y !== want.pos_y)
      report_mismatch($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
    if (got.mask !== want.mask)
      report_mismatch($sformatf("mask %h, want %h at (%0d,%0d)", got.mask, want.mask,
                                want.pos_x, want.pos_y));
    if (got.pixel_color !== want.pixel_color)
      report_mismatch($sformatf("pixel_color %h, want %h", got.pixel_color,
                                want.pixel_color));
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_stall === 1'b0) begin
      if (in_valid) begin
        render_char(in_data);
        req_cnt++;
      end
      if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= char_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, fired once when the no-idle phase begins
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && hold_now) begin
      hold_left <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) check_glyph(out_data);
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_req(input logic [7:0] ch, input logic first, input int sx,
                          input int sy, input logic [31:0] color);
    in_req_t rq;
    rq.character = ch;
    rq.first = first;
    rq.start_x = sx[8:0];
    rq.start_y = sy[7:0];
    rq.color = color;
    char_q.push_back(rq);
  endtask

  task automatic write_line_len(input logic [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    max_cols = value;
    cfg_valid <= 1'b0;
  endtask

  // wait for every request to go out and every glyph to come back
  task automatic drain;
    while (char_q.size() != 0 || in_valid || glyph_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    string glyph_set;
    int    p;
    glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz[]=-:./_<>#";
    p = $urandom_range(0, 99);
    if (p < 72) return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
    if (p < 80) return " ";
    if (p < 88) return CHAR_LF;
    if (p < 92) return CHAR_CR;
    if (p < 99) return 8'($urandom_range(1, 255));
    return CHAR_NUL;
  endfunction

  // one string with random content, or a burst of noise; n = requests queued
  task automatic queue_text(output int n);
    int len;
    int sx;
    int sy;
    n = 0;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        push_req(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 319),
                 $urandom_range(0, 255), $urandom);
        n++;
      end
      return;
    end
    sx = ($urandom_range(0, 2) == 0) ? $urandom_range(280, 319) : $urandom_range(0, 319);
    sy = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 218);
    len = $urandom_range(1, 40);
    push_req(pick_char(), 1'b1, sx, sy, $urandom);
    n++;
    repeat (len - 1) begin
      push_req(pick_char(), 1'b0, $urandom_range(0, 319), $urandom_range(0, 255),
               $urandom);
      n++;
    end
    if ($urandom_range(0, 1) == 0) begin
      push_req(CHAR_NUL, 1'b0, 0, 0, $urandom);
      n++;
    end
  endtask

  initial begin
    int cfg_plan[15];
    int sent;
    int n;
    cfg_plan = '{127, 1, 0, 5, 76, 3, 127, 1, 9, 40, 0, 2, 127, 1, 76};
    cfg_plan[9] = $urandom_range(10, 126);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 29;
    recv_stall_pct = 45;

    // directed part with the reset line length
    push_req("Q", 1'b0, 5, 5, 32'h1234_5678);           // ignored before any string
    push_req("A", 1'b1, 0, 0, 32'h0000_0000);
    push_req("z", 1'b0, 0, 0, 32'hFFFF_FFFF);           // folds to upper case
    push_req("0", 1'b0, 0, 0, 32'hA5A5_A5A5);
    push_req("9", 1'b0, 0, 0, 32'h5A5A_5A5A);
    push_req("#", 1'b0, 0, 0, 32'h0F0F_0F0F);
    push_req(" ", 1'b0, 0, 0, 32'hF0F0_F0F0);           // blank glyph
    push_req("?", 1'b0, 0, 0, 32'h1111_1111);           // no glyph of its own
    push_req(8'hFF, 1'b0, 0, 0, 32'h2222_2222);
    push_req(CHAR_CR, 1'b0, 0, 0, 32'h3333_3333);
    push_req("[", 1'b0, 0, 0, 32'h4444_4444);
    push_req(CHAR_LF, 1'b0, 0, 0, 32'h5555_5555);
    push_req("_", 1'b0, 0, 0, 32'h6666_6666);
    push_req(CHAR_NUL, 1'b0, 0, 0, 32'h7777_7777);
    push_req("B", 1'b0, 0, 0, 32'h8888_8888);           // string already ended
    push_req("8", 1'b1, 319, 218, 32'h9999_9999);       // right edge clips two columns
    push_req(CHAR_LF, 1'b0, 0, 0, 32'hAAAA_AAAA);
    push_req("C", 1'b0, 0, 0, 32'hBBBB_BBBB);           // past the screen bottom
    push_req("X", 1'b1, 316, 100, 32'hCCCC_CCCC);
    push_req("W", 1'b0, 0, 0, 32'hDDDD_DDDD);           // fully off screen
    push_req("M", 1'b1, 0, 255, 32'hEEEE_EEEE);         // origin below the screen
    drain();
    write_line_len(7'd0);                               // every glyph wraps first
    push_req("H", 1'b1, 10, 10, 32'h0123_4567);
    push_req("i", 1'b0, 0, 0, 32'h89AB_CDEF);
    push_req("/", 1'b0, 0, 0, 32'hFEDC_BA98);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 29;
          recv_stall_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        write_line_len(7'(cfg_plan[mode*5 + seg]));
        if (mode == 2 && seg == 0) hold_now = 1'b1;
        sent = 0;
        while (sent < 95) begin
          queue_text(n);
          sent += n;
        end
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (glyph_q.size() != 0)
      report_mismatch($sformatf("%0d glyphs never came out", glyph_q.size()));
    $display("%0d requests sent, %0d glyphs checked, %0d clipped at the screen edge",
             req_cnt, glyph_cnt, clipped_cnt);
    $display("%0d line wraps, %0d string stops, line lengths 0 to 127, %0d errors",
             wrap_cnt, halt_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
